[rtl/tvs_pkg.sv]
`default_nettype none
package tvs_pkg;

    // command codes carried in tuser
    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_ADVANCE = 3'd1,
        CMD_RESET   = 3'd2,
        CMD_RAND    = 3'd3,
        CMD_RESEED  = 3'd4
    } cmd_t;

    // oscillator clock divider
    localparam logic [10:0] OSC_DIV   = 11'd597;
    // floor(2^30 / 597): quotient estimate is exact or one low for 20-bit dividends
    localparam logic [20:0] RECIP_M   = 21'd1798562;

    // random register
    localparam logic [31:0] RAND_SEED = 32'h2B43_5044;
    localparam logic [31:0] RAND_TAP  = 32'h10AD_AB1E;

    // voice note codes
    localparam logic [7:0]  NOTE_COUNT   = 8'd63;
    localparam logic [7:0]  NOTE_KEEP    = 8'd0;
    localparam logic [7:0]  NOTE_RESTART = 8'd1;

    localparam logic [28:0] NOTE_TABLE [63] = '{
        29'd0, 29'd0, 29'd0,
        29'd11811160, 29'd12513387, 29'd13257490, 29'd14045832, 29'd14881203,
        29'd15765966, 29'd16703557, 29'd17696768, 29'd18749035, 29'd19864009,
        29'd21045125, 29'd22296464, 29'd23622320, 29'd25026989, 29'd26515195,
        29'd28091878, 29'd29762191, 29'd31531932, 29'd33406900, 29'd35393537,
        29'd37498071, 29'd39727803, 29'd42090250, 29'd44592927, 29'd47244640,
        29'd50053978, 29'd53030391, 29'd56183756, 29'd59524596, 29'd63064079,
        29'd66814014, 29'd70787074, 29'd74996142, 29'd79455606, 29'd84180285,
        29'd89186069, 29'd94489281, 29'd100107957, 29'd106060567, 29'd112367297,
        29'd119048977, 29'd126128157, 29'd133628029, 29'd141573933, 29'd149992288,
        29'd158911428, 29'd168360785, 29'd178371925, 29'd188978561, 29'd200215913,
        29'd212121348, 29'd224734593, 29'd238098169, 29'd252256099, 29'd267256058,
        29'd283147866, 29'd299984783, 29'd317822855, 29'd336721571, 29'd356744064
    };

    // note byte to phase increment, out-of-range notes are silent
    function automatic logic [28:0] note_freq(input logic [7:0] note);
        logic [28:0] f;
        f = '0;
        if (note < NOTE_COUNT) begin
            f = NOTE_TABLE[note[5:0]];
        end
        return f;
    endfunction

    // per-lane control, one set per voice
    typedef struct packed {
        logic        load;    // item moves into the product stage
        logic        adv;     // that item is an advance
        logic        clr_a;   // that item is a tune reset
        logic [7:0]  note;    // note byte for this voice
        logic [10:0] clocks;  // oscillator clocks to run (zero unless tick)
        logic        step;    // item moves into the accumulator stage
        logic        clr_b;   // that item is a tune reset
    } lane_ctl_t;

endpackage
`default_nettype wire

[rtl/tvs_div.sv]
`default_nettype none
// Two-stage divide of 10*elapsed by 597: reciprocal multiply, then
// one correction step.
module tvs_div
    import tvs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        en_a,
    input  wire logic        en_b,
    input  wire logic [15:0] elapsed,
    output logic      [10:0] quot_reg,
    output logic      [9:0]  rem_reg
);

    logic [19:0] prod10;
    logic [40:0] recip_prod;
    logic [19:0] p_a_reg;
    logic [10:0] qe_a_reg;
    logic [19:0] back_mul;
    logic [10:0] diff;

    // 10*e as shift-add, then quotient estimate
    assign prod10     = (20'(elapsed) << 3) + (20'(elapsed) << 1);
    assign recip_prod = 41'(prod10) * 41'(RECIP_M);

    always_ff @(posedge aclk) begin
        if (en_a) begin
            p_a_reg  <= prod10;
            qe_a_reg <= recip_prod[40:30];
        end
    end

    // remainder of the estimate is below 2*597, one fix-up
    assign back_mul = 20'(qe_a_reg) * 20'(OSC_DIV);
    assign diff     = 11'(p_a_reg - back_mul);

    always_ff @(posedge aclk) begin
        if (en_b) begin
            if (diff >= OSC_DIV) begin
                quot_reg <= qe_a_reg + 11'd1;
                rem_reg  <= 10'(diff - OSC_DIV);
            end else begin
                quot_reg <= qe_a_reg;
                rem_reg  <= diff[9:0];
            end
        end
    end

endmodule
`default_nettype wire

[rtl/tvs_lane.sv]
`default_nettype none
// One voice: frequency register, product stage and phase accumulator.
module tvs_lane
    import tvs_pkg::*;
#(
    parameter int unsigned LANE_IDX = 0
)
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire lane_ctl_t ctl,
    output logic           top_bit
);

    logic [28:0] freq_reg;
    logic [28:0] freq_next;
    logic [39:0] full_prod;
    logic [31:0] prod_reg;
    logic [31:0] acc_reg;

    // note rule: voice 2 ignores the restart code, others keep on note 0
    always_comb begin
        freq_next = freq_reg;
        if (ctl.clr_a) begin
            freq_next = '0;
        end else if (ctl.adv) begin
            if (LANE_IDX == 2) begin
                if (ctl.note != NOTE_RESTART) begin
                    freq_next = note_freq(ctl.note);
                end
            end else if (ctl.note != NOTE_KEEP) begin
                freq_next = note_freq(ctl.note);
            end
        end
    end

    assign full_prod = 40'(freq_reg) * 40'(ctl.clocks);

    // product stage, uses frequency left by earlier items
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg <= '0;
        end else if (ctl.load) begin
            freq_reg <= freq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= full_prod[31:0];
        end
    end

    // accumulator stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (ctl.step) begin
            if (ctl.clr_b) begin
                acc_reg <= '0;
            end else begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    assign top_bit = acc_reg[31];

endmodule
`default_nettype wire

[rtl/tvs_merge.sv]
`default_nettype none
// Combine the voices: four times the count of set accumulator top bits.
module tvs_merge
    import tvs_pkg::*;
#(
    parameter int unsigned NUM_VOICES = 3
)
(
    input  wire logic [NUM_VOICES-1:0] tops,
    output logic      [3:0]            level
);

    logic [1:0] cnt;

    always_comb begin
        cnt = '0;
        for (int i = 0; i < NUM_VOICES; i++) begin
            cnt = cnt + 2'(tops[i]);
        end
        level = {cnt, 2'b00};
    end

endmodule
`default_nettype wire

[rtl/three_voice_tune_synth_with_lfsr.sv]
`default_nettype none
// Three-voice tune synthesizer with a 32-bit random register. One result
// item per input item, one item per cycle sustained unless m_tready stalls
// the output. Stages: reciprocal multiply, divide correction,
// remainder/tune/random update, per-voice product (29x11 multiplier per
// lane), per-voice accumulate, whose registers also feed the output.
// Each stage moves on when the stage after it is free, so bubbles close
// up and new items are taken while a result waits.
// Input: s_tuser = cmd, s_tdata = elapsed_cycles, note_voice0..2.
// Output: m_tdata = level, tune_position, random_byte.
module three_voice_tune_synth_with_lfsr
    import tvs_pkg::*;
#(
    parameter int unsigned NUM_VOICES = 3
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] elapsed_cycles, [23:16] note_voice0, [31:24] note_voice1,
    // [39:32] note_voice2
    input  wire logic [39:0] s_tdata,
    // [2:0] cmd
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] level, [19:4] tune_position, [27:20] random_byte, [31:28] zero
    output logic      [31:0] m_tdata
);

    // stage valids and flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic free1, free2, free3, free4, free5;
    logic mv1, mv2, mv3, mv4, mv5;

    assign free5 = !v5_reg || m_tready;
    assign free4 = !v4_reg || free5;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;

    assign s_tready = free1;
    assign mv1 = s_tvalid && free1;
    assign mv2 = v1_reg && free2;
    assign mv3 = v2_reg && free3;
    assign mv4 = v3_reg && free4;
    assign mv5 = v4_reg && free5;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (free1) v1_reg <= s_tvalid;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
            if (free4) v4_reg <= v3_reg;
            if (free5) v5_reg <= v4_reg;
        end
    end

    // item payload carried down the pipe
    cmd_t       cmd1_reg, cmd2_reg, cmd3_reg;
    logic [23:0] notes1_reg, notes2_reg, notes3_reg;

    always_ff @(posedge aclk) begin
        if (mv1) begin
            cmd1_reg   <= cmd_t'(s_tuser);
            notes1_reg <= s_tdata[39:16];
        end
        if (mv2) begin
            cmd2_reg   <= cmd1_reg;
            notes2_reg <= notes1_reg;
        end
    end

    // divide by 597 over stages 1 and 2
    logic [10:0] quot;
    logic [9:0]  div_rem;

    tvs_div u_div (
        .aclk     (aclk),
        .en_a     (mv1),
        .en_b     (mv2),
        .elapsed  (s_tdata[15:0]),
        .quot_reg (quot),
        .rem_reg  (div_rem)
    );

    // stage 3: remainder loop, tune position, random register
    logic [9:0]  rem_reg, rem_next;
    logic [15:0] tune_reg, tune_next;
    logic [31:0] rand_reg, rand_next;
    logic [10:0] clocks_next;
    logic [10:0] rem_sum;
    logic [10:0] clocks3_reg;
    logic [15:0] tune3_reg, tune4_reg, tune5_reg;
    logic [7:0]  rnd3_reg, rnd4_reg, rnd5_reg;
    logic        clr4_reg;

    assign rem_sum = 11'(rem_reg) + 11'(div_rem);

    always_comb begin
        rem_next    = rem_reg;
        tune_next   = tune_reg;
        rand_next   = rand_reg;
        clocks_next = '0;
        unique case (cmd2_reg)
            CMD_TICK: begin
                if (rem_sum >= OSC_DIV) begin
                    rem_next    = 10'(rem_sum - OSC_DIV);
                    clocks_next = quot + 11'd1;
                end else begin
                    rem_next    = rem_sum[9:0];
                    clocks_next = quot;
                end
            end
            CMD_ADVANCE: begin
                if (notes2_reg[23:16] == NOTE_RESTART) begin
                    tune_next = '0;
                end else begin
                    tune_next = tune_reg + 16'd1;
                end
            end
            CMD_RESET: begin
                tune_next = '0;
            end
            CMD_RAND: begin
                rand_next = {rand_reg[10:0], rand_reg[31:11]}
                          ^ (rand_reg[10] ? RAND_TAP : 32'd0);
            end
            CMD_RESEED: begin
                rand_next = RAND_SEED;
            end
            default: begin
                rand_next = rand_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            tune_reg <= '0;
            rand_reg <= RAND_SEED;
        end else if (mv3) begin
            rem_reg  <= rem_next;
            tune_reg <= tune_next;
            rand_reg <= rand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mv3) begin
            cmd3_reg    <= cmd2_reg;
            notes3_reg  <= notes2_reg;
            clocks3_reg <= clocks_next;
            tune3_reg   <= tune_next;
            rnd3_reg    <= rand_next[7:0];
        end
        if (mv4) begin
            tune4_reg <= tune3_reg;
            rnd4_reg  <= rnd3_reg;
            clr4_reg  <= (cmd3_reg == CMD_RESET);
        end
        if (mv5) begin
            tune5_reg <= tune4_reg;
            rnd5_reg  <= rnd4_reg;
        end
    end

    // stages 4 and 5: voice lanes
    logic [NUM_VOICES-1:0] tops;

    for (genvar i = 0; i < NUM_VOICES; i++) begin : g_lane
        lane_ctl_t ctl;

        assign ctl.load   = mv4;
        assign ctl.adv    = (cmd3_reg == CMD_ADVANCE);
        assign ctl.clr_a  = (cmd3_reg == CMD_RESET);
        assign ctl.note   = notes3_reg[8*i +: 8];
        assign ctl.clocks = clocks3_reg;
        assign ctl.step   = mv5;
        assign ctl.clr_b  = clr4_reg;

        tvs_lane #(
            .LANE_IDX (i)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .top_bit (tops[i])
        );
    end

    // merge lanes into the output level
    logic [3:0] level;

    tvs_merge #(
        .NUM_VOICES (NUM_VOICES)
    ) u_merge (
        .tops  (tops),
        .level (level)
    );

    assign m_tvalid = v5_reg;
    assign m_tdata  = {4'd0, rnd5_reg, tune5_reg, level};

    // remainder of the oscillator divider stays below the divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        11'(rem_reg) < OSC_DIV)
        else $error("cycle remainder out of range");

    // a tune reset reaching the output shows silence and position zero
    a_reset_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv5 && clr4_reg) |=> (level == 4'd0 && m_tdata[19:4] == 16'd0))
        else $error("tune reset not reflected at output");

    // only ticks run oscillator clocks
    a_clocks_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && cmd3_reg != CMD_TICK) |-> clocks3_reg == 11'd0)
        else $error("clocks on a non-tick item");

    // an accepted item always occupies the first stage
    a_accept_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item lost at entry");

endmodule
`default_nettype wire

[tb/three_voice_tune_synth_with_lfsr_tb.sv]
`timescale 1ns / 100ps
module three_voice_tune_synth_with_lfsr_tb;
    import tvs_pkg::*;

    localparam int unsigned VOICES      = 3;
    localparam int          ITEM_COUNT  = 1650;
    localparam int          PHASE_ITEMS = (ITEM_COUNT + 3) / 4;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          TAIL_CYCLES = 20;

    // spare command codes, ignored by the block
    localparam logic [2:0]  CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  CMD_SPARE_LAST  = 3'd7;

    localparam logic [19:0] BUS_PER_OSC = 20'd597;
    localparam logic [31:0] LFSR_SEED   = 32'h2B43_5044;
    localparam logic [31:0] LFSR_TAP    = 32'h10AD_AB1E;

    // idle phases
    localparam logic [1:0]  PH_FREE    = 2'd0;
    localparam logic [1:0]  PH_SRC_GAP = 2'd1;
    localparam logic [1:0]  PH_SNK_GAP = 2'd2;
    localparam logic [1:0]  PH_BOTH    = 2'd3;

    // phase increment per note code
    localparam logic [28:0] STEP_TABLE [63] = '{
        29'd0, 29'd0, 29'd0,
        29'd11811160, 29'd12513387, 29'd13257490, 29'd14045832, 29'd14881203,
        29'd15765966, 29'd16703557, 29'd17696768, 29'd18749035, 29'd19864009,
        29'd21045125, 29'd22296464, 29'd23622320, 29'd25026989, 29'd26515195,
        29'd28091878, 29'd29762191, 29'd31531932, 29'd33406900, 29'd35393537,
        29'd37498071, 29'd39727803, 29'd42090250, 29'd44592927, 29'd47244640,
        29'd50053978, 29'd53030391, 29'd56183756, 29'd59524596, 29'd63064079,
        29'd66814014, 29'd70787074, 29'd74996142, 29'd79455606, 29'd84180285,
        29'd89186069, 29'd94489281, 29'd100107957, 29'd106060567, 29'd112367297,
        29'd119048977, 29'd126128157, 29'd133628029, 29'd141573933, 29'd149992288,
        29'd158911428, 29'd168360785, 29'd178371925, 29'd188978561, 29'd200215913,
        29'd212121348, 29'd224734593, 29'd238098169, 29'd252256099, 29'd267256058,
        29'd283147866, 29'd299984783, 29'd317822855, 29'd336721571, 29'd356744064
    };

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] elapsed;
        logic [7:0]  note0;
        logic [7:0]  note1;
        logic [7:0]  note2;
        logic [1:0]  phase;
        logic        drain;   // wait for all results before sending
    } tune_item_t;

    typedef struct packed {
        logic [3:0]  level;
        logic [15:0] position;
        logic [7:0]  rnd;
        logic [1:0]  phase;
    } synth_out_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // elapsed_cycles, note_voice0, note_voice1, note_voice2
    logic [2:0]  s_tuser  = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // level, tune_position, random_byte, zero pad

    tune_item_t  cmd_pend_q [$];
    synth_out_t  synth_out_q [$];
    tune_item_t  cur_item = '0;
    logic        presenting = 1'b0;
    logic [1:0]  tx_phase = PH_FREE;
    int          n_sent = 0;
    int          n_recv = 0;
    int          errors = 0;
    int          quiet_cycles = 0;

    // model state
    logic [31:0] acc_m  [3];
    logic [28:0] freq_m [3];
    logic [9:0]  rem_m;
    logic [15:0] pos_m;
    logic [31:0] lfsr_m;

    three_voice_tune_synth_with_lfsr #(
        .NUM_VOICES(VOICES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic logic [28:0] note_step(logic [7:0] note);
        logic [28:0] f;
        f = '0;
        if (note < NOTE_COUNT) begin
            f = STEP_TABLE[note];
        end
        return f;
    endfunction

    // advance model state by one item, return the result it produces
    function automatic synth_out_t synth_step(tune_item_t it);
        synth_out_t  r;
        logic [19:0] total;
        logic [10:0] clocks;
        logic [31:0] rot;
        int          cnt;
        r = '0;
        case (it.cmd)
            CMD_TICK: begin
                total  = rem_m + it.elapsed * 20'd10;
                clocks = total / BUS_PER_OSC;
                rem_m  = total % BUS_PER_OSC;
                for (int v = 0; v < VOICES; v++) begin
                    acc_m[v] = acc_m[v] + freq_m[v] * clocks;
                end
            end
            CMD_ADVANCE: begin
                pos_m = pos_m + 16'd1;
                if (it.note0 != NOTE_KEEP && VOICES > 0) begin
                    freq_m[0] = note_step(it.note0);
                end
                if (it.note1 != NOTE_KEEP && VOICES > 1) begin
                    freq_m[1] = note_step(it.note1);
                end
                if (it.note2 == NOTE_RESTART) begin
                    pos_m = '0;
                end else if (VOICES > 2) begin
                    freq_m[2] = note_step(it.note2);
                end
            end
            CMD_RESET: begin
                pos_m = '0;
                for (int v = 0; v < 3; v++) begin
                    acc_m[v]  = '0;
                    freq_m[v] = '0;
                end
            end
            CMD_RAND: begin
                rot    = {lfsr_m[10:0], lfsr_m[31:11]};
                lfsr_m = rot ^ (lfsr_m[10] ? LFSR_TAP : 32'd0);
            end
            CMD_RESEED: begin
                lfsr_m = LFSR_SEED;
            end
            default: begin
            end
        endcase
        cnt = 0;
        for (int v = 0; v < VOICES; v++) begin
            cnt += acc_m[v][31];
        end
        r.level    = 4'(cnt * 4);
        r.position = pos_m;
        r.rnd      = lfsr_m[7:0];
        r.phase    = it.phase;
        return r;
    endfunction

    // random gap decision for the sender or the receiver
    function automatic logic idle_roll(logic [1:0] ph, logic sender);
        int pct;
        pct = 0;
        if (ph == PH_BOTH) begin
            pct = 19;
        end else if ((sender && ph == PH_SRC_GAP) || (!sender && ph == PH_SNK_GAP)) begin
            pct = 59;
        end
        return $urandom_range(99) < pct;
    endfunction

    function automatic void add_item(logic [2:0] cmd, logic [15:0] el, logic [7:0] n0,
                                     logic [7:0] n1, logic [7:0] n2, logic [1:0] ph,
                                     logic drain);
        tune_item_t it;
        it.cmd     = cmd;
        it.elapsed = el;
        it.note0   = n0;
        it.note1   = n1;
        it.note2   = n2;
        it.phase   = ph;
        it.drain   = drain;
        cmd_pend_q.push_back(it);
    endfunction

    // mostly playable notes, some keep/restart/silent codes
    function automatic logic [7:0] rand_note();
        int k;
        k = $urandom_range(99);
        if (k < 8) begin
            return NOTE_KEEP;
        end else if (k < 12) begin
            return NOTE_RESTART;
        end else if (k < 15) begin
            return 8'd2;
        end else if (k < 25) begin
            return 8'($urandom_range(255, NOTE_COUNT));
        end
        return 8'($urandom_range(NOTE_COUNT - 1, 3));
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // driver: present queued items, predict on accept
    always @(posedge aclk) begin : drive_proc
        logic       accepted;
        logic       hold;
        synth_out_t res;
        if (!aresetn) begin
            presenting = 1'b0;
            s_tvalid <= 1'b0;
        end else begin
            accepted = presenting && s_tready;
            if (accepted) begin
                res = synth_step(cur_item);
                synth_out_q.push_back(res);
                n_sent <= n_sent + 1;
                presenting = 1'b0;
            end
            if (!presenting && cmd_pend_q.size() > 0) begin
                hold = 1'b0;
                if (cmd_pend_q[0].drain && (accepted || n_sent != n_recv)) begin
                    hold = 1'b1;
                end else if (idle_roll(cmd_pend_q[0].phase, 1'b1)) begin
                    hold = 1'b1;
                end
                if (!hold) begin
                    cur_item = cmd_pend_q.pop_front();
                    presenting = 1'b1;
                end
            end
            s_tvalid <= presenting;
            s_tdata  <= {cur_item.note2, cur_item.note1, cur_item.note0, cur_item.elapsed};
            s_tuser  <= cur_item.cmd;
            tx_phase <= cur_item.phase;
        end
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin : watch_proc
        synth_out_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_recv <= n_recv + 1;
                if (synth_out_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = synth_out_q.pop_front();
                    check_field("level", 16'(want.level), 16'(m_tdata[3:0]));
                    check_field("tune_position", want.position, m_tdata[19:4]);
                    check_field("random_byte", 16'(want.rnd), 16'(m_tdata[27:20]));
                    check_field("pad", 16'd0, 16'(m_tdata[31:28]));
                end
            end
            m_tready <= !idle_roll(tx_phase, 1'b0);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int         r;
        logic [1:0] ph;
        logic [2:0] cmd;
        logic [15:0] el;
        logic [7:0] n0;
        logic [7:0] n1;
        logic [7:0] n2;

        for (int v = 0; v < 3; v++) begin
            acc_m[v]  = '0;
            freq_m[v] = '0;
        end
        rem_m  = '0;
        pos_m  = '0;
        lfsr_m = LFSR_SEED;

        // directed: reset state, random steps, note rules, extremes
        add_item(CMD_TICK, 16'd0, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_RAND, 16'd0, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_RAND, 16'd0, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_RAND, 16'd0, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_RESEED, 16'd0, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_RAND, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, PH_FREE, 1'b0);
        add_item(CMD_ADVANCE, 16'd0, 8'd3, NOTE_COUNT - 1, 8'd30, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'd59, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        // note zero keeps voices 0 and 1, silences voice 2
        add_item(CMD_ADVANCE, 16'd0, NOTE_KEEP, NOTE_KEEP, NOTE_KEEP, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'd1, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        // notes above the table go silent, restart on voice 2
        add_item(CMD_ADVANCE, 16'd0, 8'hFF, NOTE_COUNT, NOTE_RESTART, PH_FREE, 1'b0);
        add_item(CMD_ADVANCE, 16'd0, 8'd2, NOTE_RESTART, 8'd2, PH_FREE, 1'b0);
        add_item(CMD_ADVANCE, 16'hFFFF, 8'd200, 8'd128, 8'hFF, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'd12345, 8'hFF, 8'hFF, 8'hFF, PH_FREE, 1'b0);
        add_item(CMD_ADVANCE, 16'd0, 8'd45, 8'd50, 8'd55, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_RESET, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'hFFFF, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        // spare codes change nothing
        add_item(CMD_SPARE_FIRST, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, PH_FREE, 1'b0);
        add_item(3'd6, 16'h5A5A, 8'd1, 8'd1, 8'd1, PH_FREE, 1'b0);
        add_item(CMD_SPARE_LAST, 16'h0000, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_ADVANCE, 16'd0, NOTE_COUNT - 1, NOTE_COUNT - 1, NOTE_COUNT - 1,
                 PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'd30000, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);
        add_item(CMD_TICK, 16'd596, 8'd0, 8'd0, 8'd0, PH_FREE, 1'b0);

        // random mix, four idle phases, each opened after a full drain
        for (int i = 0; i < ITEM_COUNT; i++) begin
            ph = 2'(i / PHASE_ITEMS);
            r  = $urandom_range(99);
            el = 16'($urandom);
            n0 = 8'($urandom);
            n1 = 8'($urandom);
            n2 = 8'($urandom);
            if (r < 40) begin
                cmd = CMD_TICK;
                if ($urandom_range(3) != 0) begin
                    el = 16'($urandom_range(2000));
                end
            end else if (r < 70) begin
                cmd = CMD_ADVANCE;
                n0 = rand_note();
                n1 = rand_note();
                n2 = rand_note();
            end else if (r < 85) begin
                cmd = CMD_RAND;
            end else if (r < 89) begin
                cmd = CMD_RESET;
            end else if (r < 93) begin
                cmd = CMD_RESEED;
            end else begin
                cmd = 3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
            end
            add_item(cmd, el, n0, n1, n2, ph, (i % PHASE_ITEMS) == 0);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // presenting covers an item popped in the same time step as this check
        do begin
            @(posedge aclk);
        end while (cmd_pend_q.size() > 0 || presenting || s_tvalid || n_sent != n_recv);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (synth_out_q.size() > 0) begin
            $display("%0t ns: results missing, expected %0d more actual 0",
                     $time, synth_out_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[three_voice_tune_synth_with_lfsr.f]
rtl/tvs_pkg.sv
rtl/tvs_div.sv
rtl/tvs_lane.sv
rtl/tvs_merge.sv
rtl/three_voice_tune_synth_with_lfsr.sv
tb/three_voice_tune_synth_with_lfsr_tb.sv
